FILE: src/lfp_pkg.sv
// Shared constants and types of the lidar frame parser.
package lfp_pkg;

    // Frame geometry.
    localparam int FRAME_BYTES       = 104;
    localparam int POINTS_PER_FRAME  = 32;
    localparam int FIRST_POINT_OFS   = 6;
    localparam int POS_START_LO      = 2;
    localparam int POS_START_HI      = 3;
    localparam int POS_STEP_LO       = 4;
    localparam int POS_STEP_HI       = 5;

    // Header bytes.
    localparam logic [7:0] HDR_FIRST = 8'hFA;
    localparam logic [7:0] HDR_DATA  = 8'h05;
    localparam logic [7:0] HDR_ERROR = 8'hEE;

    // CRC-16-CCITT, MSB first.
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // Field widths.
    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 16;
    localparam int INDEX_W = 5;
    localparam int ANGLE_W = 25;

    // Start angle in 0.01 deg to 1/28800 deg: times 288 = 256 + 32.
    localparam int ANGLE_SHIFT_HI = 8;
    localparam int ANGLE_SHIFT_LO = 5;

    // Configuration port.
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIST_LIMIT    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FALLBACK_STEP = 1'b1;
    localparam logic [WORD_W-1:0] DIST_LIMIT_RST    = 16'hFFFF;
    localparam logic [WORD_W-1:0] FALLBACK_STEP_RST = 16'd4810;

    // Control of the bit-serial CRC unit.
    typedef struct packed {
        logic start;   // load a byte and shift it in bit by bit
        logic fresh;   // begin from the initial value with this byte
        logic clear;   // return to the initial value
    } crc_ctrl_t;

endpackage

FILE: src/lfp_byte_if.sv
// Byte channel: valid, ready and one received serial byte.
interface lfp_byte_if;
    logic                         valid;
    logic                         ready;
    logic [lfp_pkg::BYTE_W-1:0]   rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: src/lfp_point_if.sv
// Point channel: valid, ready and the fields of one decoded point.
interface lfp_point_if;
    logic                         valid;
    logic                         ready;
    logic [lfp_pkg::INDEX_W-1:0]  point_index;
    logic [lfp_pkg::WORD_W-1:0]   range_mm;
    logic [lfp_pkg::BYTE_W-1:0]   energy;
    logic [lfp_pkg::ANGLE_W-1:0]  point_angle;
    logic                         point_valid;
    logic                         last_point;

    modport source (output valid, output point_index, output range_mm, output energy,
                    output point_angle, output point_valid, output last_point, input ready);
    modport sink (input valid, input point_index, input range_mm, input energy,
                  input point_angle, input point_valid, input last_point, output ready);
endinterface

FILE: src/lfp_ram.sv
// Generic simple dual-port RAM with registered read.
module lfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 104
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data valid the cycle after the enable.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: src/lfp_crc.sv
// Bit-serial CRC-16-CCITT unit: one message bit per cycle.
module lfp_crc (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lfp_pkg::crc_ctrl_t          ctrl,
    input  logic [lfp_pkg::BYTE_W-1:0]  data,
    output logic [lfp_pkg::WORD_W-1:0]  crc,
    output logic                        busy
);

    logic [lfp_pkg::WORD_W-1:0] crc_reg;
    logic [lfp_pkg::BYTE_W-1:0] shift_reg;
    logic [3:0]                 bit_cnt_reg;
    logic                       feedback;

    assign busy     = (bit_cnt_reg != 4'd0);
    assign crc      = crc_reg;
    assign feedback = crc_reg[lfp_pkg::WORD_W-1] ^ shift_reg[lfp_pkg::BYTE_W-1];

    // Load a byte, then shift one bit through the polynomial each cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg     <= lfp_pkg::CRC_INIT;
            shift_reg   <= '0;
            bit_cnt_reg <= 4'd0;
        end
        else if (ctrl.clear)
        begin
            crc_reg     <= lfp_pkg::CRC_INIT;
            bit_cnt_reg <= 4'd0;
        end
        else if (ctrl.start)
        begin
            shift_reg   <= data;
            bit_cnt_reg <= 4'(lfp_pkg::BYTE_W);
            if (ctrl.fresh)
            begin
                crc_reg <= lfp_pkg::CRC_INIT;
            end
        end
        else if (busy)
        begin
            crc_reg     <= {crc_reg[lfp_pkg::WORD_W-2:0], 1'b0}
                           ^ (feedback ? lfp_pkg::CRC_POLY : '0);
            shift_reg   <= {shift_reg[lfp_pkg::BYTE_W-2:0], 1'b0};
            bit_cnt_reg <= bit_cnt_reg - 4'd1;
        end
    end

endmodule

FILE: src/lidar_frame_parser.sv
// Top level of the lidar frame parser: header hunt, frame capture, CRC check, point output.
//
// The block takes received serial bytes on the rx channel and hunts for the header 0xFA
// followed by 0x05 (data) or 0xEE (error). It stores the whole 104-byte frame in a RAM,
// runs CRC-16-CCITT over the first 102 bytes and compares it with the little-endian trailer.
// A good data frame gives 32 beats on the pt channel, one per point, with the distance,
// energy, a valid flag against the distance limit register and the unwrapped angle.
// Error frames and frames with a bad CRC give nothing.
// Configuration goes through cfg_we, cfg_index and cfg_data; the user must write it only
// while the block is idle, and the block itself does not enforce this. A byte that enters
// the CRC holds rx.ready low while the bit-serial CRC unit shifts it in; other bytes do not.
// For each point, states EMIT_A, EMIT_B and EMIT_C read its three bytes from the single read
// port of the frame RAM, and EMIT_D loads them into the output register once it is free.
// rx.ready stays low until the last point of a frame is in the output register.
// Reset clears the parser to the header hunt and loads the register defaults.
// When the receiver stalls, the pending point holds; the next point is read ahead and then
// waits in the sequencer until the output register frees.
module lidar_frame_parser #(
    parameter int FRAME_BYTES = lfp_pkg::FRAME_BYTES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [lfp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lfp_pkg::WORD_W-1:0]        cfg_data,
    lfp_byte_if.sink                          rx,
    lfp_point_if.source                       pt
);

    localparam int AW = $clog2(FRAME_BYTES);

    typedef enum logic [1:0] {
        PH_HDR1,
        PH_HDR2,
        PH_BODY
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EMIT_A,
        ST_EMIT_B,
        ST_EMIT_C,
        ST_EMIT_D
    } state_t;

    state_t                          state_reg;
    phase_t                          phase_reg;
    logic [AW-1:0]                   count_reg;
    logic                            error_frame_reg;
    logic [AW-1:0]                   rd_ptr_reg;
    logic [lfp_pkg::INDEX_W-1:0]     pidx_reg;
    logic                            out_valid_reg;
    logic [lfp_pkg::WORD_W-1:0]      dist_limit_reg;
    logic [lfp_pkg::WORD_W-1:0]      fallback_step_reg;

    logic [lfp_pkg::WORD_W-1:0]      start_reg;
    logic [lfp_pkg::WORD_W-1:0]      step_reg;
    logic [lfp_pkg::BYTE_W-1:0]      trailer_lo_reg;
    logic [lfp_pkg::BYTE_W-1:0]      dist_lo_reg;
    logic [lfp_pkg::BYTE_W-1:0]      dist_hi_reg;
    logic [lfp_pkg::ANGLE_W-1:0]     angle_reg;
    logic [lfp_pkg::INDEX_W-1:0]     out_index_reg;
    logic [lfp_pkg::WORD_W-1:0]      out_dist_reg;
    logic [lfp_pkg::BYTE_W-1:0]      out_energy_reg;
    logic [lfp_pkg::ANGLE_W-1:0]     out_angle_reg;
    logic                            out_pvalid_reg;
    logic                            out_last_reg;

    logic                            rx_fire;
    logic                            pt_fire;
    logic                            out_free;
    logic                            crc_busy;
    logic [lfp_pkg::WORD_W-1:0]      crc_value;
    lfp_pkg::crc_ctrl_t              crc_ctrl;
    logic [lfp_pkg::BYTE_W-1:0]      b;
    logic                            is_first;
    logic                            is_hdr2;
    logic                            last_byte;
    logic                            crc_ok;
    logic                            frame_good;
    logic                            ram_we;
    logic [AW-1:0]                   ram_waddr;
    logic                            ram_re;
    logic [lfp_pkg::BYTE_W-1:0]      ram_rdata;
    logic [lfp_pkg::WORD_W-1:0]      step_eff;
    logic [lfp_pkg::WORD_W-1:0]      cur_dist;
    logic                            load_point;
    logic                            pidx_last;

    // Handshake and byte classification.
    assign rx.ready   = (state_reg == ST_IDLE) && !crc_busy;
    assign rx_fire    = rx.valid && rx.ready;
    assign pt_fire    = out_valid_reg && pt.ready;
    assign out_free   = !out_valid_reg || pt.ready;
    assign b          = rx.rx_byte;
    assign is_first   = (b == lfp_pkg::HDR_FIRST);
    assign is_hdr2    = (b == lfp_pkg::HDR_DATA) || (b == lfp_pkg::HDR_ERROR);
    assign last_byte  = (phase_reg == PH_BODY) && (count_reg == AW'(FRAME_BYTES - 1));
    assign crc_ok     = ({b, trailer_lo_reg} == crc_value);
    assign frame_good = rx_fire && last_byte && crc_ok && !error_frame_reg;

    // Point assembly.
    assign step_eff   = (step_reg == '0) ? fallback_step_reg : step_reg;
    assign cur_dist   = {dist_hi_reg, dist_lo_reg};
    assign load_point = (state_reg == ST_EMIT_D) && out_free;
    assign pidx_last  = (pidx_reg == lfp_pkg::INDEX_W'(lfp_pkg::POINTS_PER_FRAME - 1));

    // Frame RAM write and CRC requests for an accepted byte.
    always_comb
    begin
        ram_we         = 1'b0;
        ram_waddr      = count_reg;
        crc_ctrl.start = 1'b0;
        crc_ctrl.fresh = 1'b0;
        crc_ctrl.clear = rx_fire && last_byte;
        unique case (phase_reg)
            PH_HDR2:
            begin
                ram_we         = rx_fire && is_hdr2;
                ram_waddr      = AW'(1);
                crc_ctrl.start = rx_fire && is_hdr2;
            end
            PH_BODY:
            begin
                ram_we         = rx_fire;
                crc_ctrl.start = rx_fire && (count_reg < AW'(FRAME_BYTES - 2));
            end
            default:
            begin
                ram_we         = rx_fire && is_first;
                ram_waddr      = '0;
                crc_ctrl.start = rx_fire && is_first;
                crc_ctrl.fresh = 1'b1;
            end
        endcase
    end

    assign ram_re = (state_reg == ST_EMIT_A) || (state_reg == ST_EMIT_B)
                    || (state_reg == ST_EMIT_C);

    lfp_ram #(
        .WIDTH (lfp_pkg::BYTE_W),
        .DEPTH (FRAME_BYTES)
    ) u_frame_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (b),
        .re    (ram_re),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    lfp_crc u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (crc_ctrl),
        .data  (b),
        .crc   (crc_value),
        .busy  (crc_busy)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_limit_reg    <= lfp_pkg::DIST_LIMIT_RST;
            fallback_step_reg <= lfp_pkg::FALLBACK_STEP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lfp_pkg::CFG_DIST_LIMIT:    dist_limit_reg    <= cfg_data;
                lfp_pkg::CFG_FALLBACK_STEP: fallback_step_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Parser phase, emission sequencer and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            phase_reg       <= PH_HDR1;
            count_reg       <= '0;
            error_frame_reg <= 1'b0;
            rd_ptr_reg      <= '0;
            pidx_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (pt_fire && !load_point)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (rx_fire)
                    begin
                        unique case (phase_reg)
                            PH_HDR2:
                            begin
                                if (is_hdr2)
                                begin
                                    count_reg       <= AW'(2);
                                    error_frame_reg <= (b == lfp_pkg::HDR_ERROR);
                                    phase_reg       <= PH_BODY;
                                end
                                else
                                begin
                                    phase_reg <= PH_HDR1;
                                end
                            end
                            PH_BODY:
                            begin
                                if (last_byte)
                                begin
                                    count_reg <= '0;
                                    phase_reg <= PH_HDR1;
                                    if (frame_good)
                                    begin
                                        state_reg  <= ST_EMIT_A;
                                        rd_ptr_reg <= AW'(lfp_pkg::FIRST_POINT_OFS);
                                        pidx_reg   <= '0;
                                    end
                                end
                                else
                                begin
                                    count_reg <= count_reg + AW'(1);
                                end
                            end
                            default:
                            begin
                                if (is_first)
                                begin
                                    count_reg <= AW'(1);
                                    phase_reg <= PH_HDR2;
                                end
                                else
                                begin
                                    phase_reg <= PH_HDR1;
                                end
                            end
                        endcase
                    end
                end
                ST_EMIT_A:
                begin
                    rd_ptr_reg <= rd_ptr_reg + AW'(1);
                    state_reg  <= ST_EMIT_B;
                end
                ST_EMIT_B:
                begin
                    rd_ptr_reg <= rd_ptr_reg + AW'(1);
                    state_reg  <= ST_EMIT_C;
                end
                ST_EMIT_C:
                begin
                    rd_ptr_reg <= rd_ptr_reg + AW'(1);
                    state_reg  <= ST_EMIT_D;
                end
                ST_EMIT_D:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        pidx_reg      <= pidx_reg + lfp_pkg::INDEX_W'(1);
                        state_reg     <= pidx_last ? ST_IDLE : ST_EMIT_A;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Header, trailer and point data capture.
    always_ff @(posedge clk)
    begin
        if (rx_fire && (phase_reg == PH_BODY))
        begin
            case (count_reg)
                AW'(lfp_pkg::POS_START_LO): start_reg[7:0]  <= b;
                AW'(lfp_pkg::POS_START_HI): start_reg[15:8] <= b;
                AW'(lfp_pkg::POS_STEP_LO):  step_reg[7:0]   <= b;
                AW'(lfp_pkg::POS_STEP_HI):  step_reg[15:8]  <= b;
                AW'(FRAME_BYTES - 2):       trailer_lo_reg  <= b;
                default: ;
            endcase
        end
        if (frame_good)
        begin
            angle_reg <= ({9'b0, start_reg} << lfp_pkg::ANGLE_SHIFT_HI)
                         + ({9'b0, start_reg} << lfp_pkg::ANGLE_SHIFT_LO);
        end
        if (state_reg == ST_EMIT_B)
        begin
            dist_lo_reg <= ram_rdata;
        end
        if (state_reg == ST_EMIT_C)
        begin
            dist_hi_reg <= ram_rdata;
        end
        if (load_point)
        begin
            out_index_reg  <= pidx_reg;
            out_dist_reg   <= cur_dist;
            out_energy_reg <= ram_rdata;
            out_angle_reg  <= angle_reg;
            out_pvalid_reg <= (cur_dist < dist_limit_reg);
            out_last_reg   <= pidx_last;
            angle_reg      <= angle_reg + {9'b0, step_eff};
        end
    end

    // Output channel.
    assign pt.valid       = out_valid_reg;
    assign pt.point_index = out_index_reg;
    assign pt.range_mm    = out_dist_reg;
    assign pt.energy      = out_energy_reg;
    assign pt.point_angle = out_angle_reg;
    assign pt.point_valid = out_pvalid_reg;
    assign pt.last_point  = out_last_reg;

endmodule

FILE: src/lfp_checker.sv
// Port-level checks of the lidar frame parser, bound to its top level.
module lfp_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              rx_ready,
    input logic                              pt_valid,
    input logic                              pt_ready,
    input logic [lfp_pkg::INDEX_W-1:0]       pt_point_index,
    input logic [lfp_pkg::WORD_W-1:0]        pt_range_mm,
    input logic [lfp_pkg::ANGLE_W-1:0]       pt_point_angle,
    input logic                              pt_last_point
);

    // No point is offered while reset is applied.
    assert property (@(posedge clk) !rst_n |-> !pt_valid)
        else $error("point beat offered during reset");

    // The last-point flag marks exactly the final index of the frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        pt_valid |-> (pt_last_point
            == (pt_point_index == lfp_pkg::INDEX_W'(lfp_pkg::POINTS_PER_FRAME - 1))))
        else $error("last_point does not match point_index");

    // A stalled point beat holds its index, range and angle.
    assert property (@(posedge clk) disable iff (!rst_n)
        pt_valid && !pt_ready |=> pt_valid && $stable(pt_point_index)
            && $stable(pt_range_mm) && $stable(pt_point_angle))
        else $error("stalled point beat changed");

    // While a frame is still being emitted, no new byte is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        pt_valid && !pt_last_point |-> !rx_ready)
        else $error("byte accepted in the middle of point emission");

endmodule

bind lidar_frame_parser lfp_checker u_lfp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .rx_ready       (rx.ready),
    .pt_valid       (pt.valid),
    .pt_ready       (pt.ready),
    .pt_point_index (pt.point_index),
    .pt_range_mm    (pt.range_mm),
    .pt_point_angle (pt.point_angle),
    .pt_last_point  (pt.last_point)
);

FILE: tb/lfp_point_checker.sv
`timescale 1ns / 100ps
// Point checker of the lidar frame parser: follows accepted bytes, predicts points, compares.
module lfp_point_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [lfp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [lfp_pkg::WORD_W-1:0]       cfg_data,
    lfp_byte_if                              rx,
    lfp_point_if                             pt,
    output int                               mismatches,
    output int                               points_pending
);
    import lfp_pkg::*;

    // One decoded point as the block should deliver it.
    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [WORD_W-1:0]  meas_mm;
        logic [BYTE_W-1:0]  energy;
        logic [ANGLE_W-1:0] angle;
        logic               in_range;
        logic               last;
    } point_t;

    typedef enum logic [1:0] {SEEK_SYNC, SEEK_KIND, COLLECT} seek_state_t;

    seek_state_t        phase;
    logic [BYTE_W-1:0]  frame_mem [FRAME_BYTES];
    logic [6:0]         fill;
    logic               is_error;
    logic [WORD_W-1:0]  crc_acc;
    logic [WORD_W-1:0]  dist_limit;
    logic [WORD_W-1:0]  fallback_step;
    point_t             expected_points [$];
    int                 err_count;

    // CRC-16-CCITT, one byte shifted in MSB first.
    function automatic logic [WORD_W-1:0] crc_shift_byte(input logic [WORD_W-1:0] crc,
                                                         input logic [BYTE_W-1:0] b);
        logic [WORD_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        return c;
    endfunction

    // A good data frame yields one point per three-byte record.
    task automatic queue_frame_points();
        logic [WORD_W-1:0] start_cdeg;
        logic [WORD_W-1:0] step;
        logic [31:0]       angle;
        point_t            p;
        int                ofs;
        start_cdeg = {frame_mem[POS_START_HI], frame_mem[POS_START_LO]};
        step = {frame_mem[POS_STEP_HI], frame_mem[POS_STEP_LO]};
        if (step == '0)
            step = fallback_step;
        for (int i = 0; i < POINTS_PER_FRAME; i++)
        begin
            ofs = FIRST_POINT_OFS + 3 * i;
            p.index = INDEX_W'(i);
            p.meas_mm = {frame_mem[ofs + 1], frame_mem[ofs]};
            p.energy = frame_mem[ofs + 2];
            angle = 32'(start_cdeg) * 32'd288 + 32'(i) * 32'(step);
            p.angle = angle[ANGLE_W-1:0];
            p.in_range = (p.meas_mm < dist_limit);
            p.last = (i == POINTS_PER_FRAME - 1);
            expected_points.push_back(p);
        end
    endtask

    // Header hunt, frame capture and CRC check for one accepted byte.
    task automatic take_byte(input logic [BYTE_W-1:0] b);
        int pos;
        case (phase)
            SEEK_KIND:
            begin
                if (b == HDR_DATA || b == HDR_ERROR)
                begin
                    frame_mem[1] = b;
                    fill = 7'd2;
                    is_error = (b == HDR_ERROR);
                    crc_acc = crc_shift_byte(crc_acc, b);
                    phase = COLLECT;
                end
                else
                    phase = SEEK_SYNC;
            end
            COLLECT:
            begin
                pos = int'(fill);
                if (pos >= FRAME_BYTES)
                    pos = FRAME_BYTES - 1;
                frame_mem[pos] = b;
                if (pos < FRAME_BYTES - 2)
                    crc_acc = crc_shift_byte(crc_acc, b);
                fill = 7'(pos + 1);
                if (pos + 1 >= FRAME_BYTES)
                begin
                    if ({frame_mem[FRAME_BYTES-1], frame_mem[FRAME_BYTES-2]} == crc_acc
                        && !is_error)
                        queue_frame_points();
                    fill = '0;
                    phase = SEEK_SYNC;
                    crc_acc = CRC_INIT;
                end
            end
            default:
            begin
                phase = SEEK_SYNC;
                if (b == HDR_FIRST)
                begin
                    frame_mem[0] = b;
                    fill = 7'd1;
                    crc_acc = crc_shift_byte(CRC_INIT, b);
                    phase = SEEK_KIND;
                end
            end
        endcase
    endtask

    // Compare a delivered point with the oldest expected one.
    task automatic check_point();
        point_t want;
        if (expected_points.size() == 0)
        begin
            err_count++;
            if (err_count <= 10)
                $display("%0t: point with none expected: idx %0d dist %0d energy %0d angle %0d",
                         $time, pt.point_index, pt.range_mm, pt.energy, pt.point_angle);
        end
        else
        begin
            want = expected_points.pop_front();
            if (pt.point_index !== want.index || pt.range_mm !== want.meas_mm ||
                pt.energy !== want.energy || pt.point_angle !== want.angle ||
                pt.point_valid !== want.in_range || pt.last_point !== want.last)
            begin
                err_count++;
                if (err_count <= 10)
                begin
                    $display("%0t: point mismatch, expected idx %0d dist %0d energy %0d",
                             $time, want.index, want.meas_mm, want.energy);
                    $display("    angle %0d valid %0b last %0b", want.angle,
                             want.in_range, want.last);
                    $display("    got idx %0d dist %0d energy %0d angle %0d valid %0b last %0b",
                             pt.point_index, pt.range_mm, pt.energy, pt.point_angle,
                             pt.point_valid, pt.last_point);
                end
            end
        end
    endtask

    // Track configuration writes and both channels on every rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase = SEEK_SYNC;
            for (int i = 0; i < FRAME_BYTES; i++)
                frame_mem[i] = '0;
            fill = '0;
            is_error = 1'b0;
            crc_acc = CRC_INIT;
            dist_limit = DIST_LIMIT_RST;
            fallback_step = FALLBACK_STEP_RST;
            expected_points.delete();
            err_count = 0;
            mismatches <= 0;
            points_pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DIST_LIMIT:    dist_limit = cfg_data;
                    CFG_FALLBACK_STEP: fallback_step = cfg_data;
                    default:           ;
                endcase
            end
            if (rx.valid && rx.ready)
                take_byte(rx.rx_byte);
            if (pt.valid && pt.ready)
                check_point();
            mismatches <= err_count;
            points_pending <= expected_points.size();
        end
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Top of the lidar frame parser testbench: clock, reset, stimulus, stalls and verdict.
module testbench;
    import lfp_pkg::*;

    localparam int FRAME_BYTE_BUDGET = 460;
    localparam int SETTLE_CYCLES     = 24;
    localparam int END_CYCLES        = 40;
    localparam int WATCHDOG_LIMIT    = 4000;

    typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;
    typedef enum {SLOT_DATA, SLOT_ERROR, SLOT_BAD_CRC, SLOT_NOISE} slot_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [WORD_W-1:0]       cfg_data;
    int                      mismatches;
    int                      points_pending;
    int                      frame_bytes_sent;
    int unsigned             burst_left;
    int                      idle_cycles;
    logic [WORD_W-1:0]       cur_limit;

    lfp_byte_if  rx_ch ();
    lfp_point_if pt_ch ();

    lidar_frame_parser i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx        (rx_ch),
        .pt        (pt_ch)
    );

    lfp_point_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .rx             (rx_ch),
        .pt             (pt_ch),
        .mismatches     (mismatches),
        .points_pending (points_pending)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Per-byte CRC used to build well-formed trailers.
    function automatic logic [WORD_W-1:0] trailer_crc_byte(input logic [WORD_W-1:0] crc,
                                                           input logic [BYTE_W-1:0] b);
        logic [WORD_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        return c;
    endfunction

    // Offer one byte and wait for its beat; bursts end in a random gap three times in four.
    task automatic put_byte(input logic [BYTE_W-1:0] b);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0)
            begin
                rx_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
        burst_left--;
        rx_ch.valid <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge clk);
        while (!rx_ch.ready)
            @(posedge clk);
    endtask

    // Hold the sender until every expected point is out and the block is quiet.
    task automatic drain_points();
        rx_ch.valid <= 1'b0;
        @(posedge clk);
        while (points_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both registers on consecutive edges.
    task automatic set_config(input logic [WORD_W-1:0] limit, input logic [WORD_W-1:0] step);
        cfg_we <= 1'b1;
        cfg_index <= CFG_DIST_LIMIT;
        cfg_data <= limit;
        @(posedge clk);
        cfg_index <= CFG_FALLBACK_STEP;
        cfg_data <= step;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_limit = limit;
    endtask

    // A register value that is an extreme one time in four.
    function automatic logic [WORD_W-1:0] pick_reg_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return WORD_W'($urandom);
        endcase
    endfunction

    // Build one full frame with a correct trailer, optionally break it, and send it.
    task automatic send_frame(input logic [BYTE_W-1:0] kind_hdr, input bit corrupt,
                              input fill_t fill);
        logic [BYTE_W-1:0] fr [FRAME_BYTES];
        logic [WORD_W-1:0] crc;
        logic [WORD_W-1:0] start_cdeg;
        logic [WORD_W-1:0] step;
        logic [WORD_W-1:0] meas;
        int                ofs;
        int                idx;
        fr[0] = HDR_FIRST;
        fr[1] = kind_hdr;
        case (fill)
            FILL_ZERO:
                for (int i = 2; i < FRAME_BYTES - 2; i++)
                    fr[i] = 8'h00;
            FILL_ONES:
                for (int i = 2; i < FRAME_BYTES - 2; i++)
                    fr[i] = 8'hFF;
            default:
            begin
                start_cdeg = WORD_W'($urandom);
                step = ($urandom_range(0, 2) == 0) ? '0 : WORD_W'($urandom);
                {fr[POS_START_HI], fr[POS_START_LO]} = start_cdeg;
                {fr[POS_STEP_HI], fr[POS_STEP_LO]} = step;
                for (int p = 0; p < POINTS_PER_FRAME; p++)
                begin
                    // Some distances sit right at the invalid threshold.
                    if ($urandom_range(0, 3) == 0)
                        meas = cur_limit + WORD_W'($urandom_range(0, 2)) - 16'd1;
                    else
                        meas = WORD_W'($urandom);
                    ofs = FIRST_POINT_OFS + 3 * p;
                    {fr[ofs + 1], fr[ofs]} = meas;
                    fr[ofs + 2] = BYTE_W'($urandom);
                end
            end
        endcase
        crc = CRC_INIT;
        for (int i = 0; i < FRAME_BYTES - 2; i++)
            crc = trailer_crc_byte(crc, fr[i]);
        fr[FRAME_BYTES-2] = crc[7:0];
        fr[FRAME_BYTES-1] = crc[15:8];
        // A single flipped bit anywhere past the header breaks the CRC.
        if (corrupt)
        begin
            idx = $urandom_range(2, FRAME_BYTES - 1);
            fr[idx] = fr[idx] ^ BYTE_W'(1 << $urandom_range(0, 7));
        end
        for (int i = 0; i < FRAME_BYTES; i++)
            put_byte(fr[i]);
        frame_bytes_sent += FRAME_BYTES;
    endtask

    // Line noise and broken headers that never start a frame.
    task automatic send_noise();
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] prev;
        int                n;
        n = $urandom_range(1, 6);
        prev = 8'h00;
        for (int k = 0; k < n; k++)
        begin
            b = ($urandom_range(0, 2) == 0) ? HDR_FIRST : BYTE_W'($urandom);
            if (k == n - 1 && b == HDR_FIRST)
                b = 8'h00;
            if (prev == HDR_FIRST && (b == HDR_DATA || b == HDR_ERROR))
                b = 8'h00;
            put_byte(b);
            prev = b;
        end
    endtask

    // Receiver: ready follows one of four patterns, picked anew at random after each span.
    initial
    begin
        int unsigned mode;
        int unsigned span;
        int unsigned ctr;
        pt_ch.ready <= 1'b0;
        ctr = 0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            repeat (span)
            begin
                @(posedge clk);
                ctr++;
                case (mode)
                    0:       pt_ch.ready <= 1'b1;
                    1:       pt_ch.ready <= 1'($urandom_range(0, 1));
                    2:       pt_ch.ready <= ($urandom_range(0, 7) == 0);
                    default: pt_ch.ready <= ((ctr % 5) < 3);
                endcase
            end
        end
    end

    // Watchdog on cycles without any beat.
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((rx_ch.valid && rx_ch.ready) || (pt_ch.valid && pt_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin
        logic [BYTE_W-1:0] header_cases [$];
        slot_t             slot;
        int                slot_no;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_DIST_LIMIT;
        cfg_data <= '0;
        rx_ch.valid <= 1'b0;
        rx_ch.rx_byte <= '0;
        cur_limit = DIST_LIMIT_RST;
        frame_bytes_sent = 0;
        burst_left = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Header cases: a bad second byte, and a repeated first byte that is not re-examined.
        header_cases = '{8'h00, 8'hFF, HDR_FIRST, 8'h00, HDR_FIRST, HDR_FIRST, HDR_DATA,
                         HDR_FIRST, 8'h04, HDR_FIRST, 8'h06, HDR_FIRST, 8'hED,
                         HDR_FIRST, 8'hEF, HDR_FIRST, 8'hFF, 8'h00};
        foreach (header_cases[i])
            put_byte(header_cases[i]);

        // Frames: extremes first, then random frames, noise and broken frames.
        slot_no = 0;
        while (frame_bytes_sent < FRAME_BYTE_BUDGET)
        begin
            case (slot_no)
                0:
                begin
                    drain_points();
                    set_config('0, '1);
                    send_frame(HDR_DATA, 1'b0, FILL_ZERO);
                end
                1:
                begin
                    drain_points();
                    set_config('1, '0);
                    send_frame(HDR_DATA, 1'b0, FILL_ONES);
                end
                2:
                    send_frame(HDR_ERROR, 1'b0, FILL_RANDOM);
                3:
                    send_frame(HDR_DATA, 1'b1, FILL_RANDOM);
                default:
                begin
                    if ($urandom_range(0, 1) == 0)
                    begin
                        drain_points();
                        set_config(pick_reg_value(), pick_reg_value());
                    end
                    case ($urandom_range(0, 9))
                        0:       slot = SLOT_ERROR;
                        1:       slot = SLOT_BAD_CRC;
                        2:       slot = SLOT_NOISE;
                        default: slot = SLOT_DATA;
                    endcase
                    case (slot)
                        SLOT_ERROR:   send_frame(HDR_ERROR, 1'($urandom_range(0, 1)),
                                                 FILL_RANDOM);
                        SLOT_BAD_CRC: send_frame(HDR_DATA, 1'b1, FILL_RANDOM);
                        SLOT_NOISE:   send_noise();
                        default:      send_frame(HDR_DATA, 1'b0, FILL_RANDOM);
                    endcase
                end
            endcase
            if ($urandom_range(0, 2) == 0)
                send_noise();
            slot_no++;
        end

        // Let every expected point arrive, then watch for stray ones.
        rx_ch.valid <= 1'b0;
        @(posedge clk);
        while (points_pending != 0)
            @(posedge clk);
        repeat (END_CYCLES) @(posedge clk);
        if (points_pending != 0)
            $display("points never delivered: %0d", points_pending);
        if (mismatches == 0 && points_pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
